/* src/pbu_pkg.sv */
// Shared types, codes and defaults for the pattern binding unifier.
`timescale 1ns / 1ps

package pbu_pkg;

  // Default sizing of the binding table and the internal atom width
  localparam int MAX_BINDINGS_DEF = 16;
  localparam int ATOM_BITS_DEF    = 32;

  // Width of atoms on the ports, and the widest internal atom supported
  localparam int FIELD_BITS = 32;
  localparam int WIDE_BITS  = 64;

  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_LENGTH = 2'd1;
  localparam logic [1:0] CMD_BIND   = 2'd2;
  localparam logic [1:0] CMD_SUBST  = 2'd3;

  // Failure codes
  localparam logic [1:0] FAIL_NONE     = 2'd0;
  localparam logic [1:0] FAIL_LENGTH   = 2'd1;
  localparam logic [1:0] FAIL_CONFLICT = 2'd2;
  localparam logic [1:0] FAIL_FULL     = 2'd3;

  // Request beat
  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] pattern_atom;
    logic signed [31:0] matched_atom;
    logic [15:0]        pattern_length;
    logic [15:0]        match_length;
    logic signed [31:0] subject_atom;
  } req_t;

  // Response beat
  typedef struct packed {
    logic               ok;
    logic signed [31:0] result_atom;
    logic [1:0]         fail_code;
  } rsp_t;

  // Classified command as it travels through the queue
  typedef struct packed {
    logic [1:0] command;
    logic       len_ne;
  } op_ctrl_t;

endpackage

/* src/pbu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pbu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, register the read port; a read of the row being written returns the old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/pbu_front.sv */
// Front end: accept request beats, classify them and queue them for the back end.
`timescale 1ns / 1ps

module pbu_front #(
  parameter int ATOM_BITS = pbu_pkg::ATOM_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  pbu_pkg::req_t        req_data,
  output logic                 q_valid,
  input  logic                 q_pop,
  output pbu_pkg::op_ctrl_t    q_ctrl,
  output logic [ATOM_BITS-1:0] q_atom_a,
  output logic [ATOM_BITS-1:0] q_atom_b
);

  localparam int DEPTH = pbu_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WB    = pbu_pkg::WIDE_BITS;

  pbu_pkg::op_ctrl_t    ctrl_q [DEPTH];
  logic [ATOM_BITS-1:0] a_q    [DEPTH];
  logic [ATOM_BITS-1:0] b_q    [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;

  pbu_pkg::op_ctrl_t  in_ctrl;
  logic signed [31:0] sel_field;
  logic signed [WB-1:0] a_wide;
  logic signed [WB-1:0] b_wide;
  logic               push;
  logic               pop;

  // Classify: compare lengths now, pick the atom that the back end probes with
  always_comb begin
    in_ctrl.command = req_data.command;
    in_ctrl.len_ne  = req_data.pattern_length != req_data.match_length;
    sel_field = (req_data.command == pbu_pkg::CMD_SUBST) ? req_data.subject_atom
                                                          : req_data.pattern_atom;
  end

  // Sign-extend port atoms, then trim to the internal atom width
  assign a_wide = WB'(sel_field);
  assign b_wide = WB'(req_data.matched_atom);

  assign req_ready = count != CNT_W'(DEPTH);
  assign q_valid   = count != '0;
  assign push      = req_valid && req_ready;
  assign pop       = q_pop && q_valid;

  assign q_ctrl   = ctrl_q[rd_ptr];
  assign q_atom_a = a_q[rd_ptr];
  assign q_atom_b = b_q[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      ctrl_q[wr_ptr] <= in_ctrl;
      a_q[wr_ptr]    <= a_wide[ATOM_BITS-1:0];
      b_q[wr_ptr]    <= b_wide[ATOM_BITS-1:0];
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/pbu_back.sv */
// Back end: binding table probes, table updates, failure tracking and response register.
`timescale 1ns / 1ps

module pbu_back #(
  parameter int MAX_BINDINGS = pbu_pkg::MAX_BINDINGS_DEF,
  parameter int ATOM_BITS    = pbu_pkg::ATOM_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  pbu_pkg::op_ctrl_t    q_ctrl,
  input  logic [ATOM_BITS-1:0] q_atom_a,
  input  logic [ATOM_BITS-1:0] q_atom_b,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output pbu_pkg::rsp_t        rsp_data
);

  localparam int IDX_W  = $clog2(MAX_BINDINGS);
  localparam int USED_W = $clog2(MAX_BINDINGS + 1);
  localparam int WB     = pbu_pkg::WIDE_BITS;
  localparam int FB     = pbu_pkg::FIELD_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADDR = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;
  localparam logic [1:0] ST_SLOT = 2'd3;

  // Control state
  logic [1:0]              state;
  logic [1:0]              state_next;
  logic [MAX_BINDINGS-1:0] valid_bits;
  logic [USED_W-1:0]       used;
  logic [1:0]              fail;

  // Item payload
  logic [ATOM_BITS-1:0]    keys [MAX_BINDINGS];
  logic [MAX_BINDINGS-1:0] match;
  logic [ATOM_BITS-1:0]    atom;
  logic [ATOM_BITS-1:0]    mat;
  logic                    is_bind;

  // Combinational
  logic [MAX_BINDINGS-1:0] probe_match;
  logic [ATOM_BITS-1:0]    probe;
  logic [ATOM_BITS-1:0]    val;
  logic [ATOM_BITS-1:0]    ram_rdata;
  logic [IDX_W-1:0]        hit_idx;
  logic [IDX_W-1:0]        used_idx;
  logic                    hit;
  logic                    full;
  logic                    out_free;
  logic                    emit;
  logic                    load_probe;
  logic                    clr;
  logic                    append;
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [1:0]              code_next;
  logic [ATOM_BITS-1:0]    res_next;
  logic signed [WB-1:0]    res_wide;

  assign out_free = !rsp_valid || rsp_ready;
  assign q_pop    = (state == ST_IDLE) && q_valid && out_free;
  assign used_idx = used[IDX_W-1:0];
  assign full     = used == USED_W'(MAX_BINDINGS);

  // Probe every table row against one atom
  assign probe = (state == ST_IDLE) ? q_atom_a : val;

  for (genvar i = 0; i < MAX_BINDINGS; i++) begin : g_probe
    assign probe_match[i] = valid_bits[i] && (keys[i] == probe);
  end

  // Keys are unique, so the match vector is one-hot: encode by OR
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < MAX_BINDINGS; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign hit = |match;
  assign val = hit ? ram_rdata : atom;

  // Bound values, read at the hit row
  pbu_ram #(
    .WIDTH(ATOM_BITS),
    .DEPTH(MAX_BINDINGS)
  ) u_values (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(mat),
    .raddr(hit_idx),
    .rdata(ram_rdata)
  );

  // Sequence one item at a time
  always_comb begin
    state_next = state;
    emit       = 1'b0;
    load_probe = 1'b0;
    clr        = 1'b0;
    append     = 1'b0;
    code_next  = fail;
    res_next   = '0;
    unique case (state)
      ST_IDLE: begin
        if (q_pop) begin
          unique case (q_ctrl.command)
            pbu_pkg::CMD_CLEAR: begin
              clr       = 1'b1;
              emit      = 1'b1;
              code_next = pbu_pkg::FAIL_NONE;
            end
            pbu_pkg::CMD_LENGTH: begin
              emit = 1'b1;
              if (fail == pbu_pkg::FAIL_NONE && q_ctrl.len_ne) begin
                code_next = pbu_pkg::FAIL_LENGTH;
              end
            end
            pbu_pkg::CMD_BIND: begin
              if (fail != pbu_pkg::FAIL_NONE) begin
                emit = 1'b1;
              end else begin
                load_probe = 1'b1;
                state_next = ST_ADDR;
              end
            end
            pbu_pkg::CMD_SUBST: begin
              load_probe = 1'b1;
              state_next = ST_ADDR;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_ADDR: begin
        state_next = ST_DATA;
      end
      ST_DATA: begin
        if (!is_bind) begin
          if (out_free) begin
            emit       = 1'b1;
            res_next   = val;
            state_next = ST_IDLE;
          end
        end else if (val[ATOM_BITS-1]) begin
          // Resolved value is a variable: look it up as a key
          load_probe = 1'b1;
          state_next = ST_SLOT;
        end else if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
          if (val != mat) begin
            code_next = pbu_pkg::FAIL_CONFLICT;
          end
        end
      end
      ST_SLOT: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
          if (!hit) begin
            if (!full) begin
              append = 1'b1;
            end else begin
              code_next = pbu_pkg::FAIL_FULL;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Overwrite an existing binding or fill the next free row
  assign ram_we    = (state == ST_SLOT) && out_free && (hit || !full);
  assign ram_waddr = hit ? hit_idx : used_idx;

  assign res_wide = WB'(signed'(res_next));

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid_bits <= '0;
      used       <= '0;
      fail       <= pbu_pkg::FAIL_NONE;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      fail  <= code_next;
      if (clr) begin
        valid_bits <= '0;
        used       <= '0;
      end else if (append) begin
        valid_bits[used_idx] <= 1'b1;
        used                 <= used + 1'b1;
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      mat     <= q_atom_b;
      is_bind <= q_ctrl.command == pbu_pkg::CMD_BIND;
    end
    if (load_probe) begin
      atom  <= probe;
      match <= probe_match;
    end
    if (append) begin
      keys[used_idx] <= atom;
    end
    if (emit) begin
      rsp_data.ok          <= code_next == pbu_pkg::FAIL_NONE;
      rsp_data.result_atom <= res_wide[FB-1:0];
      rsp_data.fail_code   <= code_next;
    end
  end

endmodule

/* src/pattern_binding_unifier.sv */
// Top level of the pattern binding unifier: front end, command queue and back end.
//
// Usage: a request beat on req_* carries a command (clear, compare lengths,
// bind pair, substitute atom) and its operands; every request yields exactly
// one response beat on rsp_* with ok, result_atom and the sticky fail_code.
// Both channels are valid/ready; a beat moves when valid and ready are high.
// The front end classifies each beat (length compare, operand select) into a
// two-entry queue, so requests keep flowing while the back end is busy.
// Clear, compare lengths and a bind after a failure are answered from the
// idle state; substitute and other binds pass through the address state for
// the registered read of the value RAM and then the data state, and a bind
// whose value resolves to a variable makes a second table probe in the
// slot state. The back end takes one item at a time from the queue.
// Reset empties the queue, the binding table and the failure code, and
// drops any pending response. When the receiver stalls, the response
// register holds its beat and the back end waits; the queue then fills and
// req_ready falls.
`timescale 1ns / 1ps

module pattern_binding_unifier #(
  parameter int MAX_BINDINGS = pbu_pkg::MAX_BINDINGS_DEF,
  parameter int ATOM_BITS    = pbu_pkg::ATOM_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pbu_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output pbu_pkg::rsp_t rsp_data
);

  logic                 q_valid;
  logic                 q_pop;
  pbu_pkg::op_ctrl_t    q_ctrl;
  logic [ATOM_BITS-1:0] q_atom_a;
  logic [ATOM_BITS-1:0] q_atom_b;

  pbu_front #(
    .ATOM_BITS(ATOM_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_ctrl   (q_ctrl),
    .q_atom_a (q_atom_a),
    .q_atom_b (q_atom_b)
  );

  pbu_back #(
    .MAX_BINDINGS(MAX_BINDINGS),
    .ATOM_BITS   (ATOM_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_ctrl   (q_ctrl),
    .q_atom_a (q_atom_a),
    .q_atom_b (q_atom_b),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data)
  );

endmodule

/* src/pbu_checker.sv */
// Port-level checker for the pattern binding unifier, bound to the top level.
`timescale 1ns / 1ps

module pbu_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input pbu_pkg::req_t req_data,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input pbu_pkg::rsp_t rsp_data
);

  logic       rsp_fire;
  logic [1:0] last_code;

  assign rsp_fire = rsp_valid && rsp_ready;

  // Track the failure code of the last delivered response
  always_ff @(posedge clk) begin
    if (rst) begin
      last_code <= pbu_pkg::FAIL_NONE;
    end else if (rsp_fire) begin
      last_code <= rsp_data.fail_code;
    end
  end

  // Hold a stalled request beat
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req_data))
    else $error("request beat changed while stalled");

  // Hold a stalled response beat
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response beat changed while stalled");

  // Keep ok consistent with the failure code
  a_ok_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.ok == (rsp_data.fail_code == pbu_pkg::FAIL_NONE))
    else $error("ok disagrees with fail_code");

  // Drop any response on reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // Keep a failure until a clear removes it
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    rsp_fire && last_code != pbu_pkg::FAIL_NONE |->
      rsp_data.fail_code == last_code || rsp_data.fail_code == pbu_pkg::FAIL_NONE)
    else $error("failure code changed without a clear");

endmodule

bind pattern_binding_unifier pbu_checker u_pbu_checker (.*);
